>>> rtl/core/multi_button_event_scanner_unit_defines.svh
// Assertion macros shared by the button event scanner RTL
`ifndef MULTI_BUTTON_EVENT_SCANNER_UNIT_DEFINES_SVH
`define MULTI_BUTTON_EVENT_SCANNER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define MBES_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define MBES_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/mbes_pkg.sv
// Shared constants and types of the button event scanner
package mbes_pkg;

    localparam int NUM_BUTTONS_DEF = 16;
    localparam int RING_DEPTH_DEF  = 8;

    localparam int CMD_W      = 3;
    localparam int PIN_W      = 16;
    localparam int TIME_W     = 32;
    localparam int KEY_W      = 5;
    localparam int EVC_W      = 2;
    localparam int COUNT_W    = 5;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [CMD_W-1:0] CMD_SCAN        = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP         = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR       = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DRAIN_PRESS = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DRAIN_LONG  = 3'd4;

    localparam logic [EVC_W-1:0] EV_PRESSED  = 2'd0;
    localparam logic [EVC_W-1:0] EV_RELEASED = 2'd1;
    localparam logic [EVC_W-1:0] EV_CLICK    = 2'd2;
    localparam logic [EVC_W-1:0] EV_LONG     = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_BUTTON_COUNT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_MASK  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS   = 4'd3;

    localparam logic [TIME_W-1:0] DEBOUNCE_RST   = 32'd20;
    localparam logic [TIME_W-1:0] LONG_PRESS_RST = 32'd1000;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_DEBOUNCE = 2'd1,
        PH_PRESSED  = 2'd2,
        PH_LONG     = 2'd3
    } t_phase;

endpackage

>>> rtl/core/multi_button_event_scanner_unit.sv
// Button event scanner top level: debounce, click and long-press detection with event ring
//
//  channel  | signals                                      | beat taken when
//  ---------+----------------------------------------------+--------------------------
//  in       | i_command, i_pin_levels, i_now               | i_in_valid & o_in_ready
//  out      | o_event_valid, o_key_id, o_event_code,       | o_out_valid & i_out_ready
//           | o_pressed_mask, o_long_press_mask            |
//  cfg      | i_cfg_index, i_cfg_data                      | i_cfg_valid & o_cfg_ready
//
// Scan: accept, then fetch and evaluate steps per button in use, a push step per click,
// then the result; one shared subtract-compare unit does every threshold test.
// Pop and drain: accept, a check and a take per entry taken, a last check if the ring
// runs dry, then the result. Clear and unknown commands: accept and result. The result
// register frees o_in_ready while a finished result waits; a stalled output holds the next
// result in its last step. Reset clears button state and ring pointers, presets registers.
`include "multi_button_event_scanner_unit_defines.svh"

module multi_button_event_scanner_unit #(
    parameter int NUM_BUTTONS = mbes_pkg::NUM_BUTTONS_DEF,
    parameter int RING_DEPTH  = mbes_pkg::RING_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [mbes_pkg::CMD_W-1:0]       i_command,
    input  logic [mbes_pkg::PIN_W-1:0]       i_pin_levels,
    input  logic [mbes_pkg::TIME_W-1:0]      i_now,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_event_valid,
    output logic [mbes_pkg::KEY_W-1:0]       o_key_id,
    output logic [mbes_pkg::EVC_W-1:0]       o_event_code,
    output logic [mbes_pkg::PIN_W-1:0]       o_pressed_mask,
    output logic [mbes_pkg::PIN_W-1:0]       o_long_press_mask,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [mbes_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mbes_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam int CNT_W = $clog2(NUM_BUTTONS + 1);
    localparam int RW    = $clog2(RING_DEPTH);
    localparam int ENT_W = mbes_pkg::KEY_W + mbes_pkg::EVC_W;

    typedef enum logic [2:0] {
        S_IDLE, S_FETCH, S_EVAL, S_PUSH2, S_RCHK, S_RTAKE, S_DONE
    } t_state;

    // configuration registers
    logic [mbes_pkg::COUNT_W-1:0] r_button_count;
    logic [mbes_pkg::PIN_W-1:0]   r_active_mask;
    logic [mbes_pkg::TIME_W-1:0]  r_debounce;
    logic [mbes_pkg::TIME_W-1:0]  r_long_time;

    // sequencer and captured beat
    t_state                       r_state, n_state;
    logic [mbes_pkg::CMD_W-1:0]   r_cmd, n_cmd;
    logic [mbes_pkg::PIN_W-1:0]   r_pins, n_pins;
    logic [mbes_pkg::TIME_W-1:0]  r_now, n_now;
    logic [IDX_W-1:0]             r_idx, n_idx;
    logic [CNT_W-1:0]             used;

    // per-button state
    mbes_pkg::t_phase             r_phase [NUM_BUTTONS];
    mbes_pkg::t_phase             n_phase [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0]       r_stable, n_stable;
    logic [NUM_BUTTONS-1:0]       r_lfired, n_lfired;
    logic [mbes_pkg::TIME_W-1:0]  start_mem [NUM_BUTTONS];
    logic [mbes_pkg::TIME_W-1:0]  r_start_q;
    logic                         start_we;

    // event ring
    logic [ENT_W-1:0]             ring_mem [RING_DEPTH];
    logic [ENT_W-1:0]             r_ring_q;
    logic [RW-1:0]                r_wr, n_wr, r_rd, n_rd;
    logic                         push_req, push_ok;
    logic [mbes_pkg::EVC_W-1:0]   push_code;
    logic [mbes_pkg::KEY_W-1:0]   push_key;

    // pending result and output register
    logic                         r_ev_valid, n_ev_valid;
    logic [mbes_pkg::KEY_W-1:0]   r_ev_key, n_ev_key;
    logic [mbes_pkg::EVC_W-1:0]   r_ev_code, n_ev_code;
    logic                         r_out_valid, n_out_valid;
    logic                         r_o_ev_valid, n_o_ev_valid;
    logic [mbes_pkg::KEY_W-1:0]   r_o_key, n_o_key;
    logic [mbes_pkg::EVC_W-1:0]   r_o_code, n_o_code;
    logic [mbes_pkg::PIN_W-1:0]   r_o_pmask, n_o_pmask;
    logic [mbes_pkg::PIN_W-1:0]   r_o_lmask, n_o_lmask;

    // datapath helpers
    logic [NUM_BUTTONS-1:0]       raw_vec, in_use, pm_full, lm_full;
    logic [mbes_pkg::TIME_W-1:0]  elapsed, thr;
    logic                         ge, raw, advance, in_acc;
    mbes_pkg::t_phase             cur;
    logic [mbes_pkg::EVC_W-1:0]   want;

    function automatic logic [RW-1:0] ring_next(input logic [RW-1:0] p);
        ring_next = (p == RW'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;

    assign used = (32'(r_button_count) > NUM_BUTTONS) ? CNT_W'(NUM_BUTTONS)
                                                     : CNT_W'(r_button_count);

    // pins beyond the port read as 0, as does their active level
    assign raw_vec = ~(NUM_BUTTONS'(r_pins) ^ NUM_BUTTONS'(r_active_mask));
    assign raw     = raw_vec[r_idx];
    assign cur     = r_phase[r_idx];

    // shared subtract-compare unit
    assign elapsed = r_now - r_start_q;
    assign thr     = (cur == mbes_pkg::PH_DEBOUNCE) ? r_debounce : r_long_time;
    assign ge      = (elapsed >= thr);

    assign push_key = mbes_pkg::KEY_W'(32'(r_idx) + 32'd1);
    assign want     = (r_cmd == mbes_pkg::CMD_DRAIN_PRESS) ? mbes_pkg::EV_PRESSED
                                                           : mbes_pkg::EV_LONG;

    always_comb begin
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            in_use[i]  = (32'(i) < 32'(used));
            pm_full[i] = r_stable[i] & in_use[i];
            lm_full[i] = (r_phase[i] == mbes_pkg::PH_LONG) & in_use[i];
        end
    end

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_pins       = r_pins;
        n_now        = r_now;
        n_idx        = r_idx;
        n_phase      = r_phase;
        n_stable     = r_stable;
        n_lfired     = r_lfired;
        n_wr         = r_wr;
        n_rd         = r_rd;
        n_ev_valid   = r_ev_valid;
        n_ev_key     = r_ev_key;
        n_ev_code    = r_ev_code;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_o_ev_valid = r_o_ev_valid;
        n_o_key      = r_o_key;
        n_o_code     = r_o_code;
        n_o_pmask    = r_o_pmask;
        n_o_lmask    = r_o_lmask;
        start_we     = 1'b0;
        push_req     = 1'b0;
        push_code    = mbes_pkg::EV_PRESSED;
        push_ok      = 1'b0;
        advance      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_cmd      = i_command;
                    n_pins     = i_pin_levels;
                    n_now      = i_now;
                    n_idx      = '0;
                    n_ev_valid = 1'b0;
                    n_ev_key   = '0;
                    n_ev_code  = '0;
                    case (i_command)
                        mbes_pkg::CMD_SCAN: begin
                            n_state = (used == '0) ? S_DONE : S_FETCH;
                        end
                        mbes_pkg::CMD_POP, mbes_pkg::CMD_DRAIN_PRESS,
                        mbes_pkg::CMD_DRAIN_LONG: begin
                            n_state = S_RCHK;
                        end
                        mbes_pkg::CMD_CLEAR: begin
                            for (int i = 0; i < NUM_BUTTONS; i++) begin
                                n_phase[i] = mbes_pkg::PH_IDLE;
                            end
                            n_stable = '0;
                            n_lfired = '0;
                            n_wr     = '0;
                            n_rd     = '0;
                            n_state  = S_DONE;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            // start time of this button lands in r_start_q
            S_FETCH: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                advance = 1'b1;
                case (cur)
                    mbes_pkg::PH_IDLE: begin
                        if (raw != r_stable[r_idx]) begin
                            n_phase[r_idx] = mbes_pkg::PH_DEBOUNCE;
                            start_we       = 1'b1;
                        end
                    end
                    mbes_pkg::PH_DEBOUNCE: begin
                        if (raw == r_stable[r_idx]) begin
                            n_phase[r_idx] = mbes_pkg::PH_IDLE;
                        end else if (ge) begin
                            n_stable[r_idx] = raw;
                            push_req        = 1'b1;
                            if (raw) begin
                                n_phase[r_idx]  = mbes_pkg::PH_PRESSED;
                                start_we        = 1'b1;
                                n_lfired[r_idx] = 1'b0;
                                push_code       = mbes_pkg::EV_PRESSED;
                            end else begin
                                n_phase[r_idx] = mbes_pkg::PH_IDLE;
                                push_code      = mbes_pkg::EV_RELEASED;
                            end
                        end
                    end
                    mbes_pkg::PH_PRESSED: begin
                        if (!raw) begin
                            start_we        = 1'b1;
                            n_stable[r_idx] = 1'b0;
                            n_phase[r_idx]  = mbes_pkg::PH_IDLE;
                            push_req        = 1'b1;
                            push_code       = mbes_pkg::EV_RELEASED;
                            // click follows in the next cycle
                            advance         = 1'b0;
                            n_state         = S_PUSH2;
                        end else if ((r_long_time != '0) && ge && !r_lfired[r_idx]) begin
                            n_lfired[r_idx] = 1'b1;
                            n_phase[r_idx]  = mbes_pkg::PH_LONG;
                            push_req        = 1'b1;
                            push_code       = mbes_pkg::EV_LONG;
                        end
                    end
                    mbes_pkg::PH_LONG: begin
                        if (!raw) begin
                            start_we        = 1'b1;
                            n_stable[r_idx] = 1'b0;
                            n_phase[r_idx]  = mbes_pkg::PH_IDLE;
                            push_req        = 1'b1;
                            push_code       = mbes_pkg::EV_RELEASED;
                        end
                    end
                    default: begin
                        n_phase[r_idx] = mbes_pkg::PH_IDLE;
                    end
                endcase
            end
            S_PUSH2: begin
                push_req  = 1'b1;
                push_code = mbes_pkg::EV_CLICK;
                advance   = 1'b1;
            end
            // entry at the read pointer lands in r_ring_q
            S_RCHK: begin
                n_state = (r_wr == r_rd) ? S_DONE : S_RTAKE;
            end
            S_RTAKE: begin
                n_rd = ring_next(r_rd);
                if ((r_cmd == mbes_pkg::CMD_POP) ||
                    (r_ring_q[mbes_pkg::EVC_W-1:0] == want)) begin
                    n_ev_valid = 1'b1;
                    n_ev_key   = r_ring_q[ENT_W-1:mbes_pkg::EVC_W];
                    n_ev_code  = r_ring_q[mbes_pkg::EVC_W-1:0];
                    n_state    = S_DONE;
                end else begin
                    n_state = S_RCHK;
                end
            end
            S_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_o_ev_valid = r_ev_valid;
                    n_o_key      = r_ev_key;
                    n_o_code     = r_ev_code;
                    n_o_pmask    = mbes_pkg::PIN_W'(pm_full);
                    n_o_lmask    = mbes_pkg::PIN_W'(lm_full);
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (push_req) begin
            push_ok = (ring_next(r_wr) != r_rd);
            if (push_ok) begin
                n_wr = ring_next(r_wr);
            end
        end

        if (advance) begin
            if (32'(r_idx) + 32'd1 == 32'(used)) begin
                n_state = S_DONE;
            end else begin
                n_idx   = r_idx + 1'b1;
                n_state = S_FETCH;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_button_count <= '0;
            r_active_mask  <= '0;
            r_debounce     <= mbes_pkg::DEBOUNCE_RST;
            r_long_time    <= mbes_pkg::LONG_PRESS_RST;
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                r_phase[i] <= mbes_pkg::PH_IDLE;
            end
            r_stable       <= '0;
            r_lfired       <= '0;
            r_wr           <= '0;
            r_rd           <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_stable    <= n_stable;
            r_lfired    <= n_lfired;
            r_wr        <= n_wr;
            r_rd        <= n_rd;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    mbes_pkg::REG_BUTTON_COUNT: begin
                        r_button_count <= i_cfg_data[mbes_pkg::COUNT_W-1:0];
                    end
                    mbes_pkg::REG_ACTIVE_MASK: begin
                        r_active_mask <= i_cfg_data[mbes_pkg::PIN_W-1:0];
                    end
                    mbes_pkg::REG_DEBOUNCE: begin
                        r_debounce <= i_cfg_data;
                    end
                    mbes_pkg::REG_LONG_PRESS: begin
                        r_long_time <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
        end
        r_cmd        <= n_cmd;
        r_pins       <= n_pins;
        r_now        <= n_now;
        r_idx        <= n_idx;
        r_ev_valid   <= n_ev_valid;
        r_ev_key     <= n_ev_key;
        r_ev_code    <= n_ev_code;
        r_o_ev_valid <= n_o_ev_valid;
        r_o_key      <= n_o_key;
        r_o_code     <= n_o_code;
        r_o_pmask    <= n_o_pmask;
        r_o_lmask    <= n_o_lmask;
    end

    // start-time store: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (start_we) begin
            start_mem[r_idx] <= r_now;
        end
        r_start_q <= start_mem[r_idx];
    end

    // event ring store
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            ring_mem[r_wr] <= {push_key, push_code};
        end
        r_ring_q <= ring_mem[r_rd];
    end

    assign o_out_valid       = r_out_valid;
    assign o_event_valid     = r_o_ev_valid;
    assign o_key_id          = r_o_key;
    assign o_event_code      = r_o_code;
    assign o_pressed_mask    = r_o_pmask;
    assign o_long_press_mask = r_o_lmask;

    `MBES_ASSERT_NXT(a_push_keeps_gap, push_ok, r_wr != r_rd, "ring push filled the last slot")
    `MBES_ASSERT_IMP(a_long_is_pressed, o_out_valid, (o_long_press_mask & ~o_pressed_mask) == '0, "long-press bit without pressed bit")
    `MBES_ASSERT_IMP(a_empty_result, o_out_valid && !o_event_valid, (o_key_id == '0) && (o_event_code == '0), "empty result carries event fields")
    `MBES_ASSERT_IMP(a_scan_in_range, r_state == S_EVAL, 32'(r_idx) < 32'(used), "scan index beyond buttons in use")

endmodule

>>> dv/multi_button_event_scanner_unit_tb.sv
// Self-checking testbench for the button event scanner: directed rows, then random phases
module multi_button_event_scanner_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mbes_pkg::*;

    localparam int NBTN           = NUM_BUTTONS_DEF;
    localparam int PHASES         = 10;
    localparam int PHASE_ITEMS    = 103;
    localparam int IDLE_PAUSE     = 8;
    localparam int DRAIN_TAIL     = 20;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SHOWN_FAILS    = 10;

    // command codes the block does not know
    localparam logic [CMD_W-1:0] CMD_RSVD_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD_MID   = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD_LAST  = 3'd7;

    typedef struct packed {
        logic             ev_valid;
        logic [KEY_W-1:0] key;
        logic [EVC_W-1:0] code;
        logic [PIN_W-1:0] pmask;
        logic [PIN_W-1:0] lmask;
    } scan_result_t;

    localparam scan_result_t NO_EVENT = '0;

    typedef enum logic [1:0] {
        ROW_ITEM,
        ROW_CHK,
        ROW_REG
    } row_kind_t;

    // value is the tick for items and the write data for register rows
    typedef struct packed {
        row_kind_t              kind;
        logic [CMD_W-1:0]       cmd;
        logic [PIN_W-1:0]       pins;
        logic [TIME_W-1:0]      value;
        logic [CFG_IDX_W-1:0]   reg_idx;
        scan_result_t           want;
    } dir_row_t;

    localparam int DIR_ROWS = 36;

    dir_row_t dir_table [DIR_ROWS] = '{
        '{ROW_CHK,  CMD_POP,         16'h0000, 32'h0000_0000, REG_BUTTON_COUNT, NO_EVENT},
        '{ROW_CHK,  CMD_RSVD_FIRST,  16'hFFFF, 32'hFFFF_FFFF, REG_BUTTON_COUNT, NO_EVENT},
        '{ROW_CHK,  CMD_RSVD_MID,    16'h0000, 32'h0000_0000, REG_BUTTON_COUNT, NO_EVENT},
        '{ROW_CHK,  CMD_RSVD_LAST,   16'hAAAA, 32'h5555_5555, REG_BUTTON_COUNT, NO_EVENT},
        '{ROW_CHK,  CMD_SCAN,        16'hFFFF, 32'h0000_0000, REG_BUTTON_COUNT, NO_EVENT},
        '{ROW_CHK,  CMD_DRAIN_LONG,  16'h0000, 32'h0000_0000, REG_BUTTON_COUNT, NO_EVENT},
        '{ROW_REG,  CMD_SCAN,        16'h0000, 32'd31,        REG_BUTTON_COUNT, NO_EVENT},
        '{ROW_REG,  CMD_SCAN,        16'h0000, 32'h0000_FFFF, REG_ACTIVE_MASK,  NO_EVENT},
        '{ROW_REG,  CMD_SCAN,        16'h0000, 32'd0,         REG_DEBOUNCE,     NO_EVENT},
        '{ROW_REG,  CMD_SCAN,        16'h0000, 32'd5,         REG_LONG_PRESS,   NO_EVENT},
        '{ROW_ITEM, CMD_SCAN,        16'hFFFF, 32'd100,       REG_BUTTON_COUNT, NO_EVENT},
        '{ROW_ITEM, CMD_SCAN,        16'hFFFF, 32'd100,       REG_BUTTON_COUNT, NO_EVENT},
        '{ROW_ITEM, CMD_POP,         16'h0000, 32'd0,         REG_BUTTON_COUNT, NO_EVENT},
        '{ROW_ITEM, CMD_SCAN,        16'hFFFF, 32'd105,       REG_BUTTON_COUNT, NO_EVENT},
        '{ROW_ITEM, CMD_DRAIN_LONG,  16'h0000, 32'd0,         REG_BUTTON_COUNT, NO_EVENT},
        '{ROW_ITEM, CMD_POP,         16'h0000, 32'd0,         REG_BUTTON_COUNT, NO_EVENT},
        '{ROW_ITEM, CMD_SCAN,        16'h0000, 32'd106,       REG_BUTTON_COUNT, NO_EVENT},
        '{ROW_ITEM, CMD_DRAIN_PRESS, 16'h0000, 32'd0,         REG_BUTTON_COUNT, NO_EVENT},
        '{ROW_ITEM, CMD_CLEAR,       16'hFFFF, 32'hFFFF_FFFF, REG_BUTTON_COUNT, NO_EVENT},
        '{ROW_CHK,  CMD_POP,         16'h0000, 32'd0,         REG_BUTTON_COUNT, NO_EVENT},
        '{ROW_REG,  CMD_SCAN,        16'h0000, 32'd16,        REG_BUTTON_COUNT, NO_EVENT},
        '{ROW_REG,  CMD_SCAN,        16'h0000, 32'd0,         REG_ACTIVE_MASK,  NO_EVENT},
        '{ROW_REG,  CMD_SCAN,        16'h0000, 32'hFFFF_FFFF, REG_DEBOUNCE,     NO_EVENT},
        '{ROW_REG,  CMD_SCAN,        16'h0000, 32'd0,         REG_LONG_PRESS,   NO_EVENT},
        '{ROW_ITEM, CMD_SCAN,        16'h0000, 32'h0000_0000, REG_BUTTON_COUNT, NO_EVENT},
        '{ROW_ITEM, CMD_SCAN,        16'h0000, 32'hFFFF_FFFE, REG_BUTTON_COUNT, NO_EVENT},
        '{ROW_ITEM, CMD_SCAN,        16'h0000, 32'hFFFF_FFFF, REG_BUTTON_COUNT, NO_EVENT},
        '{ROW_ITEM, CMD_SCAN,        16'hFFFF, 32'd3,         REG_BUTTON_COUNT, NO_EVENT},
        '{ROW_ITEM, CMD_POP,         16'h0000, 32'd0,         REG_BUTTON_COUNT, NO_EVENT},
        '{ROW_ITEM, CMD_DRAIN_PRESS, 16'h0000, 32'd0,         REG_BUTTON_COUNT, NO_EVENT},
        '{ROW_ITEM, CMD_CLEAR,       16'h0000, 32'd0,         REG_BUTTON_COUNT, NO_EVENT},
        '{ROW_REG,  CMD_SCAN,        16'h0000, 32'd1,         REG_BUTTON_COUNT, NO_EVENT},
        '{ROW_REG,  CMD_SCAN,        16'h0000, 32'h0000_5555, REG_ACTIVE_MASK,  NO_EVENT},
        '{ROW_REG,  CMD_SCAN,        16'h0000, 32'd2,         REG_DEBOUNCE,     NO_EVENT},
        '{ROW_ITEM, CMD_SCAN,        16'hFFFF, 32'd3,         REG_BUTTON_COUNT, NO_EVENT},
        '{ROW_ITEM, CMD_SCAN,        16'hFFFF, 32'd5,         REG_BUTTON_COUNT, NO_EVENT}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [CMD_W-1:0]      i_command = CMD_SCAN;
    logic [PIN_W-1:0]      i_pin_levels = '0;
    logic [TIME_W-1:0]     i_now = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic                  o_event_valid;
    logic [KEY_W-1:0]      o_key_id;
    logic [EVC_W-1:0]      o_event_code;
    logic [PIN_W-1:0]      o_pressed_mask;
    logic [PIN_W-1:0]      o_long_press_mask;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = REG_BUTTON_COUNT;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    multi_button_event_scanner_unit DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow registers and button state of the scanner
    logic [COUNT_W-1:0] cfg_count;
    logic [PIN_W-1:0]   cfg_active;
    logic [TIME_W-1:0]  cfg_debounce;
    logic [TIME_W-1:0]  cfg_long;

    t_phase            btn_phase     [NBTN];
    logic              btn_stable    [NBTN];
    logic [TIME_W-1:0] btn_since     [NBTN];
    logic              btn_long_done [NBTN];

    logic [KEY_W-1:0]  evq_key  [RING_DEPTH_DEF];
    logic [EVC_W-1:0]  evq_code [RING_DEPTH_DEF];
    logic [2:0]        evq_wr;
    logic [2:0]        evq_rd;

    scan_result_t pending_results [$];
    int unsigned  fail_count = 0;
    int unsigned  quiet_cycles = 0;
    bit           src_gaps = 1'b1;
    bit           sink_stalls = 1'b1;
    int unsigned  stall_left = 0;

    function automatic void clear_buttons();
        for (int i = 0; i < NBTN; i++) begin
            btn_phase[i]     = PH_IDLE;
            btn_stable[i]    = 1'b0;
            btn_since[i]     = '0;
            btn_long_done[i] = 1'b0;
        end
        evq_wr = '0;
        evq_rd = '0;
    endfunction

    // one slot stays free, so a push into a ring holding seven is dropped
    function automatic void push_event(logic [KEY_W-1:0] key, logic [EVC_W-1:0] code);
        logic [2:0] nxt;
        nxt = evq_wr + 3'd1;
        if (nxt != evq_rd) begin
            evq_key[evq_wr]  = key;
            evq_code[evq_wr] = code;
            evq_wr           = nxt;
        end
    endfunction

    function automatic bit pop_event(output logic [KEY_W-1:0] key,
                                     output logic [EVC_W-1:0] code);
        key  = '0;
        code = '0;
        if (evq_wr == evq_rd)
            return 1'b0;
        key    = evq_key[evq_rd];
        code   = evq_code[evq_rd];
        evq_rd = evq_rd + 3'd1;
        return 1'b1;
    endfunction

    function automatic scan_result_t predict_scan_result(logic [CMD_W-1:0] cmd,
                                                         logic [PIN_W-1:0] pins,
                                                         logic [TIME_W-1:0] now);
        scan_result_t      r;
        int                n;
        logic              raw;
        logic [TIME_W-1:0] elapsed;
        logic [KEY_W-1:0]  k;
        logic [EVC_W-1:0]  e;
        logic [EVC_W-1:0]  want_code;
        r = NO_EVENT;
        n = (cfg_count > NBTN) ? NBTN : int'(cfg_count);
        case (cmd)
            CMD_SCAN: begin
                for (int i = 0; i < n; i++) begin
                    raw     = (pins[i] == cfg_active[i]);
                    elapsed = now - btn_since[i];
                    case (btn_phase[i])
                        PH_IDLE: begin
                            if (raw != btn_stable[i]) begin
                                btn_phase[i] = PH_DEBOUNCE;
                                btn_since[i] = now;
                            end
                        end
                        PH_DEBOUNCE: begin
                            if (raw == btn_stable[i]) begin
                                btn_phase[i] = PH_IDLE;
                            end else if (elapsed >= cfg_debounce) begin
                                btn_stable[i] = raw;
                                if (raw) begin
                                    btn_phase[i]     = PH_PRESSED;
                                    btn_since[i]     = now;
                                    btn_long_done[i] = 1'b0;
                                    push_event(KEY_W'(i + 1), EV_PRESSED);
                                end else begin
                                    btn_phase[i] = PH_IDLE;
                                    push_event(KEY_W'(i + 1), EV_RELEASED);
                                end
                            end
                        end
                        PH_PRESSED: begin
                            if (!raw) begin
                                btn_since[i]  = now;
                                btn_stable[i] = 1'b0;
                                btn_phase[i]  = PH_IDLE;
                                push_event(KEY_W'(i + 1), EV_RELEASED);
                                push_event(KEY_W'(i + 1), EV_CLICK);
                            end else if (cfg_long != '0 && elapsed >= cfg_long &&
                                         !btn_long_done[i]) begin
                                btn_long_done[i] = 1'b1;
                                btn_phase[i]     = PH_LONG;
                                push_event(KEY_W'(i + 1), EV_LONG);
                            end
                        end
                        PH_LONG: begin
                            if (!raw) begin
                                btn_since[i]  = now;
                                btn_stable[i] = 1'b0;
                                btn_phase[i]  = PH_IDLE;
                                push_event(KEY_W'(i + 1), EV_RELEASED);
                            end
                        end
                        default: btn_phase[i] = PH_IDLE;
                    endcase
                end
            end
            CMD_POP: begin
                if (pop_event(k, e)) begin
                    r.ev_valid = 1'b1;
                    r.key      = k;
                    r.code     = e;
                end
            end
            CMD_CLEAR: clear_buttons();
            CMD_DRAIN_PRESS, CMD_DRAIN_LONG: begin
                want_code = (cmd == CMD_DRAIN_PRESS) ? EV_PRESSED : EV_LONG;
                // drop entries until the wanted kind turns up or the ring runs dry
                while (pop_event(k, e)) begin
                    if (e == want_code) begin
                        r.ev_valid = 1'b1;
                        r.key      = k;
                        r.code     = e;
                        break;
                    end
                end
            end
            default: ;
        endcase
        for (int i = 0; i < n; i++) begin
            r.pmask[i] = btn_stable[i];
            r.lmask[i] = (btn_phase[i] == PH_LONG);
        end
        return r;
    endfunction

    task automatic send_item(logic [CMD_W-1:0] cmd, logic [PIN_W-1:0] pins,
                             logic [TIME_W-1:0] now, bit typed, scan_result_t want);
        scan_result_t predicted;
        i_cfg_valid  <= 1'b0;
        i_in_valid   <= 1'b1;
        i_command    <= cmd;
        i_pin_levels <= pins;
        i_now        <= now;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = predict_scan_result(cmd, pins, now);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_BUTTON_COUNT: cfg_count    = data[COUNT_W-1:0];
            REG_ACTIVE_MASK:  cfg_active   = data[PIN_W-1:0];
            REG_DEBOUNCE:     cfg_debounce = data;
            REG_LONG_PRESS:   cfg_long     = data;
            default: ;
        endcase
    endtask

    // drop both valids, let every result come back, then wait out an idle pause
    task automatic wait_idle();
        i_in_valid  <= 1'b0;
        i_cfg_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (IDLE_PAUSE) @(posedge i_clk);
    endtask

    task automatic source_gap();
        if (src_gaps && $urandom_range(0, 7) == 0) begin
            i_in_valid  <= 1'b0;
            i_cfg_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
    endtask

    // receiver: ready drops for random bursts
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (sink_stalls && $urandom_range(0, 7) == 0) begin
            stall_left  <= $urandom_range(1, 19) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_results
        scan_result_t got;
        scan_result_t exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = {o_event_valid, o_key_id, o_event_code, o_pressed_mask, o_long_press_mask};
            if (pending_results.size() == 0) begin
                if (fail_count < SHOWN_FAILS)
                    $display("%0t: result beat with nothing pending: valid=%0d key=%0d code=%0d",
                             $realtime, got.ev_valid, got.key, got.code);
                fail_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (got.ev_valid !== exp_r.ev_valid || got.key !== exp_r.key ||
                    got.code !== exp_r.code || got.pmask !== exp_r.pmask ||
                    got.lmask !== exp_r.lmask) begin
                    if (fail_count < SHOWN_FAILS)
                        $display({"%0t: mismatch exp valid=%0d key=%0d code=%0d pressed=%h ",
                                  "long=%h, got valid=%0d key=%0d code=%0d pressed=%h long=%h"},
                                 $realtime, exp_r.ev_valid, exp_r.key, exp_r.code,
                                 exp_r.pmask, exp_r.lmask, got.ev_valid, got.key, got.code,
                                 got.pmask, got.lmask);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        logic [CMD_W-1:0]  cmd;
        logic [PIN_W-1:0]  pins;
        logic [TIME_W-1:0] now;
        logic [PIN_W-1:0]  held_pins;
        logic [TIME_W-1:0] tick;
        logic [31:0]       reg_count;
        logic [31:0]       reg_mask;
        logic [31:0]       reg_deb;
        logic [31:0]       reg_long;
        bit                last_was_reg;
        int                pick;

        cfg_count    = '0;
        cfg_active   = '0;
        cfg_debounce = DEBOUNCE_RST;
        cfg_long     = LONG_PRESS_RST;
        clear_buttons();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        last_was_reg = 1'b0;
        foreach (dir_table[r]) begin
            if (dir_table[r].kind == ROW_REG) begin
                if (!last_was_reg)
                    wait_idle();
                write_reg(dir_table[r].reg_idx, dir_table[r].value);
                last_was_reg = 1'b1;
            end else begin
                source_gap();
                send_item(dir_table[r].cmd, dir_table[r].pins, dir_table[r].value,
                          dir_table[r].kind == ROW_CHK, dir_table[r].want);
                last_was_reg = 1'b0;
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            // the last phase runs with no idling on either side
            src_gaps    <= (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
            sink_stalls <= (p != PHASES - 1) && ($urandom_range(0, 3) != 0);

            case (p % 4)
                0:       reg_count = 32'd16;
                1:       reg_count = $urandom_range(17, 31);
                default: reg_count = $urandom_range(1, 16);
            endcase
            reg_mask = (p == 0) ? 32'h0 : (p == 1) ? 32'hFFFF : {16'h0, 16'($urandom())};
            case (p)
                2:       reg_deb = 32'h0;
                3:       reg_deb = 32'hFFFF_FFFF;
                4:       reg_deb = $urandom();
                default: reg_deb = $urandom_range(0, 6);
            endcase
            case (p)
                1, 6:    reg_long = 32'h0;
                5:       reg_long = 32'hFFFF_FFFF;
                7:       reg_long = $urandom();
                default: reg_long = $urandom_range(1, 20);
            endcase
            write_reg(REG_BUTTON_COUNT, reg_count);
            write_reg(REG_ACTIVE_MASK, reg_mask);
            write_reg(REG_DEBOUNCE, reg_deb);
            write_reg(REG_LONG_PRESS, reg_long);

            // some phases start just short of the tick wrapping round
            tick      = (p % 3 == 0) ? 32'hFFFF_FFC0 + $urandom_range(0, 63) : $urandom();
            held_pins = PIN_W'($urandom());

            repeat (PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                pins = PIN_W'($urandom());
                now  = $urandom();
                if (pick < 62) begin
                    cmd  = CMD_SCAN;
                    tick = tick + (($urandom_range(0, 9) == 0) ? $urandom_range(0, 60)
                                                               : $urandom_range(0, 3));
                    held_pins = held_pins ^ 16'($urandom() & $urandom() & $urandom() &
                                                $urandom());
                    pins = held_pins;
                    now  = tick;
                end else if (pick < 72) begin
                    cmd = CMD_POP;
                end else if (pick < 78) begin
                    cmd = CMD_DRAIN_PRESS;
                end else if (pick < 84) begin
                    cmd = CMD_DRAIN_LONG;
                end else if (pick < 86) begin
                    cmd = CMD_CLEAR;
                end else if (pick < 89) begin
                    cmd = CMD_W'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST));
                end else begin
                    // noise: a scan with random levels at a random tick
                    cmd = CMD_SCAN;
                end
                source_gap();
                send_item(cmd, pins, now, 1'b0, NO_EVENT);
            end
        end

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> multi_button_event_scanner_unit.f
+incdir+rtl/core
rtl/core/mbes_pkg.sv
rtl/core/multi_button_event_scanner_unit.sv
dv/multi_button_event_scanner_unit_tb.sv
